### hw/rtl/swkr_pkg.sv
package swkr_pkg;

   localparam int VALUE_W  = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_SWEEP
   } state_type;

endpackage

### hw/rtl/swkr_if.sv
interface swkr_req_if;
   import swkr_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            op;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output op, output value, input ready);
   modport sink (input valid, input op, input value, output ready);
endinterface

interface swkr_rsp_if;
   import swkr_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  read_value;
   logic [STATUS_W-1:0]        status;
   logic                       is_empty;
   logic [COUNT_W-1:0]         fill_level;
   logic [COUNT_W-1:0]         removed_count;

   modport source (output valid, output read_value, output status, output is_empty,
                   output fill_level, output removed_count, input ready);
   modport sink (input valid, input read_value, input status, input is_empty,
                 input fill_level, input removed_count, output ready);
endinterface

### hw/rtl/swkr_ram.sv
module swkr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### hw/rtl/swkr_ctrl.sv
module swkr_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   swkr_req_if.sink                      req_chan,
   swkr_rsp_if.source                    rsp_chan,
   output logic                          mem_we,
   output logic [$clog2(DEPTH)-1:0]      mem_waddr,
   output logic [swkr_pkg::VALUE_W-1:0]  mem_wdata,
   output logic                          mem_re,
   output logic [$clog2(DEPTH)-1:0]      mem_raddr,
   input  logic [swkr_pkg::VALUE_W-1:0]  mem_rdata
);
   import swkr_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);

   state_type        state_ff, state_in;
   logic [LW-1:0]    level_ff, level_in;
   logic [LW-1:0]    rd_ff, rd_in;
   logic [LW-1:0]    wr_ff, wr_in;
   logic [LW-1:0]    removed_ff, removed_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic             cmp_v_ff, cmp_v_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pop_ff, rsp_pop_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [LW-1:0]    rsp_level_ff, rsp_level_in;
   logic [LW-1:0]    rsp_removed_ff, rsp_removed_in;

   logic             accept;
   logic [LW-1:0]    level_dec;

   assign level_dec = LW'(level_ff - 1'b1);
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         cmp_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         cmp_v_ff     <= cmp_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff          <= rd_in;
      wr_ff          <= wr_in;
      removed_ff     <= removed_in;
      key_ff         <= key_in;
      rsp_pop_ff     <= rsp_pop_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   always_comb begin
      state_in       = state_ff;
      level_in       = level_ff;
      rd_in          = rd_ff;
      wr_in          = wr_ff;
      removed_in     = removed_ff;
      key_in         = key_ff;
      cmp_v_in       = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_pop_in     = rsp_pop_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_removed_in = rsp_removed_ff;
      mem_we         = 1'b0;
      mem_waddr      = level_ff[AW-1:0];
      mem_wdata      = req_chan.value;
      mem_re         = 1'b0;
      mem_raddr      = level_dec[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Every operation except a non-trivial remove answers in the next cycle.
               rsp_valid_in   = 1'b1;
               rsp_pop_in     = 1'b0;
               rsp_status_in  = ST_OK;
               rsp_removed_in = '0;
               case (req_chan.op)
                  OP_PUSH: begin
                     if (level_ff == LW'(DEPTH)) begin
                        rsp_status_in = ST_OVERFLOW;
                     end else begin
                        mem_we   = 1'b1;
                        level_in = LW'(level_ff + 1'b1);
                     end
                  end
                  OP_POP: begin
                     if (level_ff == '0) begin
                        rsp_status_in = ST_UNDERFLOW;
                     end else begin
                        mem_re     = 1'b1;
                        rsp_pop_in = 1'b1;
                        level_in   = level_dec;
                     end
                  end
                  OP_REMOVE: begin
                     if (level_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        key_in       = req_chan.value;
                        rd_in        = '0;
                        wr_in        = '0;
                        removed_in   = '0;
                        state_in     = S_SWEEP;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_level_in = level_in;
            end
         end
         S_SWEEP: begin
            // Reads run one entry ahead of the compare; the write pointer never
            // passes the read pointer, so no entry is overwritten before it is read.
            if (rd_ff != level_ff) begin
               mem_re    = 1'b1;
               mem_raddr = rd_ff[AW-1:0];
               rd_in     = LW'(rd_ff + 1'b1);
               cmp_v_in  = 1'b1;
            end
            if (cmp_v_ff) begin
               if (mem_rdata == key_ff) begin
                  removed_in = LW'(removed_ff + 1'b1);
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = wr_ff[AW-1:0];
                  mem_wdata = mem_rdata;
                  wr_in     = LW'(wr_ff + 1'b1);
               end
            end else if (rd_ff == level_ff) begin
               level_in       = wr_ff;
               rsp_valid_in   = 1'b1;
               rsp_pop_in     = 1'b0;
               rsp_status_in  = ST_OK;
               rsp_level_in   = wr_ff;
               rsp_removed_in = removed_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.read_value    = rsp_pop_ff ? signed'(mem_rdata) : '0;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.is_empty      = (rsp_level_ff == '0);
   assign rsp_chan.fill_level    = COUNT_W'(rsp_level_ff);
   assign rsp_chan.removed_count = COUNT_W'(rsp_removed_ff);
endmodule

### hw/rtl/stack_with_key_removal.sv
// Bounded last-in-first-out stack of signed 32-bit words with a remove-key
// operation that deletes every entry equal to a key and keeps the rest in order.
// Requests arrive on req_chan (op, value); every request yields exactly one beat
// on rsp_chan with read_value, status, is_empty, fill_level and removed_count.
// Push, pop and unused op codes give their result in the cycle after acceptance,
// and with rsp_chan.ready held high the block takes one such request per cycle.
// Remove-key sweeps the stored entries through the single entry memory, one
// entry per cycle, and req_chan.ready stays low until the sweep ends. A remove
// on an empty stack answers in the cycle after acceptance.
// Overflow and underflow are flagged in status and leave the stack unchanged.
// A result waits in the output register while rsp_chan.ready is low; a new
// request is taken in the same cycle as the waiting beat leaves, not before.
// Synchronous reset empties the stack and drops any pending result; the entry
// memory itself is not cleared, as only entries below the fill level are read.
module stack_with_key_removal #(
   parameter int DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   swkr_req_if.sink   req_chan,
   swkr_rsp_if.source rsp_chan
);
   import swkr_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [VALUE_W-1:0] mem_wdata;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;
   logic [VALUE_W-1:0] mem_rdata;

   swkr_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   swkr_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );
endmodule

### tb/tb_top.sv
module tb_top;
   import swkr_pkg::*;

   localparam int STACK_DEPTH = 64;
   localparam int REQUEST_TARGET = 1000;
   localparam int CALM_TAIL = 120;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 80;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] value;
   } stack_request_type;

   typedef struct {
      logic signed [VALUE_W-1:0] read_value;
      status_type                status;
      logic                      is_empty;
      logic [COUNT_W-1:0]        fill_level;
      logic [COUNT_W-1:0]        removed_count;
   } stack_result_type;

   logic clock;
   logic reset;

   swkr_req_if req_chan ();
   swkr_rsp_if rsp_chan ();

   stack_with_key_removal #(
      .DEPTH(STACK_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   stack_request_type pending_requests[$];
   stack_result_type expected_results[$];
   logic signed [VALUE_W-1:0] shadow_store[STACK_DEPTH];
   int unsigned shadow_level;
   logic signed [VALUE_W-1:0] key_pool[4];
   int counted_requests;
   int req_gap;
   int rsp_stall;
   int idle_cycles;
   bit failed;
   bit calm;
   stack_request_type next_request;
   stack_result_type wanted;

   // Applies one accepted request to the shadow stack and records its result.
   task automatic predict_stack_op(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value);
      stack_result_type res;
      int unsigned wr;
      int unsigned removed;
      res.read_value = '0;
      res.status = ST_OK;
      removed = 0;
      case (op)
         OP_PUSH: begin
            if (shadow_level >= STACK_DEPTH) begin
               res.status = ST_OVERFLOW;
            end else begin
               shadow_store[shadow_level] = value;
               shadow_level++;
            end
         end
         OP_POP: begin
            if (shadow_level == 0) begin
               res.status = ST_UNDERFLOW;
            end else begin
               shadow_level--;
               res.read_value = shadow_store[shadow_level];
            end
         end
         OP_REMOVE: begin
            wr = 0;
            for (int unsigned rd = 0; rd < shadow_level; rd++) begin
               if (shadow_store[rd] == value) begin
                  removed++;
               end else begin
                  shadow_store[wr] = shadow_store[rd];
                  wr++;
               end
            end
            shadow_level = wr;
         end
         default: begin
         end
      endcase
      res.is_empty = (shadow_level == 0);
      res.fill_level = shadow_level[COUNT_W-1:0];
      res.removed_count = removed[COUNT_W-1:0];
      expected_results.push_back(res);
   endtask

   task automatic queue_request(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value);
      stack_request_type r;
      r.op = op;
      r.value = value;
      pending_requests.push_back(r);
      if (op != OP_NONE)
         counted_requests++;
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_key();
      return key_pool[$urandom_range(0, 3)];
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_push_value();
      if ($urandom_range(0, 1) == 0)
         return pick_key();
      return $urandom;
   endfunction

   task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failed = 1'b1;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Stimulus: directed corners first, then random sequences with a small key pool
   // so that remove-key finds matches.
   initial begin
      logic signed [VALUE_W-1:0] k;
      int pick;
      counted_requests = 0;

      queue_request(OP_POP, 32'sd17);
      queue_request(OP_REMOVE, 32'sd0);
      queue_request(OP_NONE, VALUE_MAX);
      queue_request(OP_PUSH, VALUE_MIN);
      queue_request(OP_PUSH, VALUE_MAX);
      queue_request(OP_PUSH, 32'sd0);
      queue_request(OP_PUSH, -32'sd1);
      queue_request(OP_PUSH, VALUE_MIN);
      queue_request(OP_NONE, VALUE_MIN);
      queue_request(OP_REMOVE, VALUE_MIN);
      queue_request(OP_REMOVE, 32'sd5);
      queue_request(OP_PUSH, 32'sd5);
      queue_request(OP_REMOVE, -32'sd1);
      queue_request(OP_POP, VALUE_MAX);
      queue_request(OP_POP, 32'sd0);
      queue_request(OP_POP, -32'sd1);
      queue_request(OP_POP, 32'sd0);
      queue_request(OP_REMOVE, VALUE_MAX);

      while (counted_requests < REQUEST_TARGET) begin
         for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 5))
               0: key_pool[i] = VALUE_MIN;
               1: key_pool[i] = VALUE_MAX;
               2: key_pool[i] = 32'sd0;
               default: key_pool[i] = $urandom;
            endcase
         end
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            // Pushes past the depth from any starting level, so overflow is reached.
            repeat ($urandom_range(STACK_DEPTH + 2, STACK_DEPTH + 6))
               queue_request(OP_PUSH, pick_push_value());
         end else if (pick < 5) begin
            repeat (STACK_DEPTH + 6)
               queue_request(OP_POP, $urandom);
         end else if (pick < 7) begin
            // Empty the stack, fill it with one key, then remove the lot.
            k = pick_key();
            repeat (STACK_DEPTH + 1)
               queue_request(OP_POP, $urandom);
            repeat (STACK_DEPTH + 2)
               queue_request(OP_PUSH, k);
            queue_request(OP_REMOVE, k);
         end else begin
            repeat ($urandom_range(10, 40)) begin
               pick = $urandom_range(0, 99);
               if (pick < 45)
                  queue_request(OP_PUSH, pick_push_value());
               else if (pick < 72)
                  queue_request(OP_POP, $urandom);
               else if (pick < 90)
                  queue_request(OP_REMOVE, pick_key());
               else if (pick < 95)
                  queue_request(OP_REMOVE, $urandom);
               else
                  queue_request(OP_NONE, $urandom);
            end
         end
      end

      @(negedge reset);
      while (pending_requests.size() != 0 || req_chan.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failed)
         $display("CHECKS FAILED");
      else
         $display("ALL CHECKS PASSED");
      $finish;
   end

   always @(posedge clock) begin
      calm = pending_requests.size() < CALM_TAIL;
   end

   // Request driver: a beat is held until accepted; gaps are only opened between beats.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_stack_op(req_chan.op, req_chan.value);
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap > 0) begin
               req_chan.valid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (pending_requests.size() != 0) begin
               next_request = pending_requests.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.op <= next_request.op;
               req_chan.value <= next_request.value;
               if (!calm && $urandom_range(0, 9) == 0)
                  req_gap <= $urandom_range(1, 14);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("result beat arrived with no request outstanding");
               failed = 1'b1;
            end else begin
               wanted = expected_results.pop_front();
               check_field("read_value", wanted.read_value, rsp_chan.read_value);
               check_field("status", wanted.status, rsp_chan.status);
               check_field("is_empty", wanted.is_empty, rsp_chan.is_empty);
               check_field("fill_level", wanted.fill_level, rsp_chan.fill_level);
               check_field("removed_count", wanted.removed_count, rsp_chan.removed_count);
            end
         end
         if (rsp_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0)
               rsp_stall <= $urandom_range(1, 14);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule
